/* design/ctcu_pkg.sv */
package ctcu_pkg;

	localparam int DEPTH_DEF       = 128;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int SAMPLE_W = 32;
	localparam int TIME_W   = 64;
	localparam int POS_W    = 7;
	localparam int LENGTH_W = 8;

	localparam logic REQ_CAPTURE = 1'b0;
	localparam logic REQ_READ    = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cap_en;
	} ctrl_status_t;

endpackage

/* design/circular_trace_capture_unit.sv */
// Circular trace buffer. busy stays low, so an item is taken in every cycle that start is
// high; its result appears on done for exactly one cycle, in the cycle after the item was
// taken, from the registered read port of the sample memory. The receiver cannot stall:
// a result not captured in its done cycle is gone. Capture items store the sample only
// while capture_enable (cfg_we/cfg_wdata) is set; trace_length is the entry count after
// the item, and read_value/read_time are zero unless read_valid is set.
module circular_trace_capture_unit #(
	parameter int DEPTH       = ctcu_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = ctcu_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [ctcu_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [ctcu_pkg::TIME_W-1:0]   sample_time,
	input  logic [ctcu_pkg::POS_W-1:0]    read_position,
	output logic                          done,
	output logic [ctcu_pkg::SAMPLE_W-1:0] read_value,
	output logic [ctcu_pkg::TIME_W-1:0]   read_time,
	output logic [ctcu_pkg::LENGTH_W-1:0] trace_length,
	output logic                          read_valid
);

	ctcu_pkg::ctrl_cmd_t    cmd;
	ctcu_pkg::ctrl_status_t status;

	ctcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.busy     (busy),
		.done     (done),
		.cmd      (cmd)
	);

	ctcu_datapath #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.status        (status),
		.sample_value  (sample_value),
		.sample_time   (sample_time),
		.read_position (read_position),
		.read_value    (read_value),
		.read_time     (read_time),
		.trace_length  (trace_length),
		.read_valid    (read_valid)
	);

endmodule

/* design/ctcu_ram.sv */
module ctcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ctcu_ctrl.sv */
module ctcu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  req_type,
	input  ctcu_pkg::ctrl_status_t status,
	output logic                  busy,
	output logic                  done,
	output ctcu_pkg::ctrl_cmd_t   cmd
);

	ctcu_pkg::ctrl_state_t state_q, state_d;
	logic                  accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		unique case (state_q)
			ctcu_pkg::ST_IDLE: state_d = accept ? ctcu_pkg::ST_RESP : ctcu_pkg::ST_IDLE;
			ctcu_pkg::ST_RESP: state_d = accept ? ctcu_pkg::ST_RESP : ctcu_pkg::ST_IDLE;
			default:           state_d = ctcu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = accept;
		cmd.wr   = accept && (req_type == ctcu_pkg::REQ_CAPTURE) && status.cap_en;
		cmd.rd   = accept && (req_type == ctcu_pkg::REQ_READ);
		unique case (state_q)
			ctcu_pkg::ST_IDLE: done = 1'b0;
			ctcu_pkg::ST_RESP: done = 1'b1;
			default:           done = 1'b0;
		endcase
	end

endmodule

/* design/ctcu_datapath.sv */
module ctcu_datapath #(
	parameter int DEPTH       = ctcu_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = ctcu_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  ctcu_pkg::ctrl_cmd_t           cmd,
	output ctcu_pkg::ctrl_status_t        status,
	input  logic [ctcu_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [ctcu_pkg::TIME_W-1:0]   sample_time,
	input  logic [ctcu_pkg::POS_W-1:0]    read_position,
	output logic [ctcu_pkg::SAMPLE_W-1:0] read_value,
	output logic [ctcu_pkg::TIME_W-1:0]   read_time,
	output logic [ctcu_pkg::LENGTH_W-1:0] trace_length,
	output logic                          read_valid
);

	localparam int STORE_W = (VALUE_WIDTH < ctcu_pkg::SAMPLE_W) ? VALUE_WIDTH
	                                                            : ctcu_pkg::SAMPLE_W;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = (LEN_W > ctcu_pkg::POS_W) ? LEN_W : ctcu_pkg::POS_W;
	localparam int SUM_W   = CMP_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);

	logic               cap_en_q;
	logic [PTR_W-1:0]   wp_q;
	logic               wrapped_q;
	logic               valid_q;

	logic [PTR_W:0]     wp_inc;
	logic [LEN_W-1:0]   len;
	logic [CMP_W-1:0]   len_c, pos_c;
	logic [SUM_W-1:0]   sum, slot;
	logic               hit;
	logic [PTR_W-1:0]   raddr;
	logic [STORE_W-1:0] val_rd;
	logic [ctcu_pkg::TIME_W-1:0]       time_rd;
	logic [STORE_W+ctcu_pkg::SAMPLE_W-1:0] val_ext;
	logic [LEN_W+ctcu_pkg::LENGTH_W-1:0]   len_ext;

	assign status.cap_en = cap_en_q;

	assign wp_inc = {1'b0, wp_q} + (PTR_W + 1)'(1);
	assign len    = wrapped_q ? LEN_W'(DEPTH) : LEN_W'(wp_q);
	assign len_c  = CMP_W'(len);
	assign pos_c  = CMP_W'(read_position);
	assign hit    = pos_c < len_c;

	// oldest entry sits at the write pointer once the buffer has wrapped
	assign sum    = SUM_W'(wp_q) + SUM_W'(pos_c);
	always_comb begin
		if (!wrapped_q) begin
			slot = SUM_W'(pos_c);
		end else if (sum >= DEPTH_S) begin
			slot = sum - DEPTH_S;
		end else begin
			slot = sum;
		end
	end
	assign raddr = slot[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q  <= 1'b0;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_en_q <= cfg_wdata;
			end
			if (cmd.wr) begin
				if (wp_inc >= DEPTH_P) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_inc[PTR_W-1:0];
				end
			end
			valid_q <= cmd.load && cmd.rd && hit;
		end
	end

	ctcu_ram #(
		.WIDTH (STORE_W),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (wp_q),
		.wdata (sample_value[STORE_W-1:0]),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (val_rd)
	);

	ctcu_ram #(
		.WIDTH (ctcu_pkg::TIME_W),
		.DEPTH (DEPTH)
	) u_time_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (wp_q),
		.wdata (sample_time),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (time_rd)
	);

	assign val_ext      = {{ctcu_pkg::SAMPLE_W{1'b0}}, val_rd};
	assign len_ext      = {{ctcu_pkg::LENGTH_W{1'b0}}, len};
	assign read_value   = valid_q ? val_ext[ctcu_pkg::SAMPLE_W-1:0] : '0;
	assign read_time    = valid_q ? time_rd : '0;
	assign read_valid   = valid_q;
	assign trace_length = len_ext[ctcu_pkg::LENGTH_W-1:0];

endmodule

/* design/ctcu_checker.sv */
module ctcu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          req_type,
	input logic                          done,
	input logic                          read_valid,
	input logic [ctcu_pkg::SAMPLE_W-1:0] read_value,
	input logic [ctcu_pkg::TIME_W-1:0]   read_time
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("item accepted without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted item");

	a_capture_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == ctcu_pkg::REQ_CAPTURE) |=> !read_valid)
		else $error("capture item reported a valid read");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !read_valid) |-> (read_value == '0 && read_time == '0))
		else $error("invalid result carries data");

	a_valid_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		read_valid |-> done)
		else $error("read_valid outside a result cycle");

endmodule

bind circular_trace_capture_unit ctcu_checker u_ctcu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.req_type   (req_type),
	.done       (done),
	.read_valid (read_valid),
	.read_value (read_value),
	.read_time  (read_time)
);
